>>> hw/rtl/ppe_pkg.sv
// Shared types, constants and fixed-point helpers of the particle pool engine.
// Used by ppe_div and particle_pool_engine; depends on nothing else.
`timescale 1ns / 1ps
`default_nettype none

package ppe_pkg;

    localparam int SLOT_W = 10;
    localparam int QUO_W  = 16;

    localparam logic [1:0] OP_EMIT = 2'd0;
    localparam logic [1:0] OP_TICK = 2'd1;
    localparam logic [1:0] OP_READ = 2'd2;

    localparam logic [2:0] REG_COLOR_START  = 3'd0;
    localparam logic [2:0] REG_COLOR_FINISH = 3'd1;
    localparam logic [2:0] REG_SIZE_START   = 3'd2;
    localparam logic [2:0] REG_SIZE_SPREAD  = 3'd3;
    localparam logic [2:0] REG_SIZE_FINISH  = 3'd4;
    localparam logic [2:0] REG_LIFE_SPAN    = 3'd5;
    localparam logic [2:0] REG_SPREAD_X     = 3'd6;
    localparam logic [2:0] REG_SPREAD_Y     = 3'd7;

    // Q16.16 gains: 2*pi, 0.3 and 0.01
    localparam logic signed [32:0] ROT_GAIN  = 33'sd411775;
    localparam logic signed [32:0] MOVE_GAIN = 33'sd19661;
    localparam logic signed [32:0] SPIN_GAIN = 33'sd655;
    localparam logic signed [32:0] HALF_Q16  = 33'sd32768;

    typedef struct packed {
        logic [1:0]         op;
        logic signed [31:0] pos_x;
        logic signed [31:0] pos_y;
        logic signed [31:0] vel_x;
        logic signed [31:0] vel_y;
        logic [63:0]        random_bits;
        logic [30:0]        time_step;
        logic [9:0]         slot_index;
    } item_t;

    typedef struct packed {
        logic [9:0]         slot;
        logic               active;
        logic signed [31:0] out_pos_x;
        logic signed [31:0] out_pos_y;
        logic signed [31:0] out_size;
        logic [31:0]        out_color;
        logic signed [31:0] out_rotation;
    } result_t;

    typedef struct packed {
        logic               live;
        logic signed [31:0] pos_x;
        logic signed [31:0] pos_y;
        logic signed [31:0] vel_x;
        logic signed [31:0] vel_y;
        logic signed [31:0] rot;
        logic signed [31:0] life_tot;
        logic signed [31:0] life_rem;
        logic signed [31:0] size_s;
        logic signed [31:0] size_f;
        logic [31:0]        col_s;
        logic [31:0]        col_f;
    } entry_t;

    // floor(y / 65536 + 1/2)
    function automatic logic signed [49:0] rnd16(input logic signed [65:0] y);
        logic signed [65:0] t;
        t = (y + 66'sd32768) >>> 16;
        return t[49:0];
    endfunction

    function automatic logic signed [31:0] sat32(input logic signed [63:0] v);
        logic signed [31:0] r;
        if (v > 64'sd2147483647)
            r = 32'sh7fffffff;
        else if (v < -64'sd2147483648)
            r = 32'sh80000000;
        else
            r = v[31:0];
        return r;
    endfunction

endpackage

`default_nettype wire

>>> hw/rtl/ppe_ram.sv
// Generic single-write, single-read RAM with registered read data.
// No dependencies.
`timescale 1ns / 1ps
`default_nettype none

module ppe_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 1024
) (
    input  wire logic                     clk,
    input  wire logic                     we,
    input  wire logic [$clog2(DEPTH)-1:0] waddr,
    input  wire logic [WIDTH-1:0]         wdata,
    input  wire logic [$clog2(DEPTH)-1:0] raddr,
    output logic      [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata <= mem[raddr];
    end

endmodule

`default_nettype wire

>>> hw/rtl/ppe_mul.sv
// Shared signed 33 x 33 multiplier with a registered product.
// Depends on nothing; the sequencer in particle_pool_engine drives it.
`timescale 1ns / 1ps
`default_nettype none

module ppe_mul (
    input  wire logic               clk,
    input  wire logic signed [32:0] a,
    input  wire logic signed [32:0] b,
    output logic signed [65:0]      prod
);

    always_ff @(posedge clk)
    begin
        prod <= a * b;
    end

endmodule

`default_nettype wire

>>> hw/rtl/ppe_div.sv
// Restoring divider, one quotient bit a cycle: quo = floor(num * 65536 / den).
// Requires num < den. Uses ppe_pkg.
`timescale 1ns / 1ps
`default_nettype none

module ppe_div (
    input  wire logic                         clk,
    input  wire logic                         rst_n,
    input  wire logic                         start,
    input  wire logic [30:0]                  num,
    input  wire logic [30:0]                  den,
    output logic                              done,
    output logic [ppe_pkg::QUO_W-1:0]         quo
);

    logic [30:0]               rem_reg, rem_next;
    logic [30:0]               den_reg, den_next;
    logic [ppe_pkg::QUO_W-1:0] q_reg, q_next;
    logic [3:0]                cnt_reg, cnt_next;
    logic                      busy_reg, busy_next;
    logic                      done_reg, done_next;
    logic [31:0]               r2;

    always_comb
    begin
        rem_next  = rem_reg;
        den_next  = den_reg;
        q_next    = q_reg;
        cnt_next  = cnt_reg;
        busy_next = busy_reg;
        done_next = 1'b0;
        r2        = {rem_reg, 1'b0};
        if (start)
        begin
            rem_next  = num;
            den_next  = den;
            cnt_next  = 4'(ppe_pkg::QUO_W - 1);
            busy_next = 1'b1;
        end
        else if (busy_reg)
        begin
            // shift in one bit, subtract where it fits
            if (r2 >= {1'b0, den_reg})
            begin
                rem_next = 31'(r2 - {1'b0, den_reg});
                q_next   = {q_reg[ppe_pkg::QUO_W-2:0], 1'b1};
            end
            else
            begin
                rem_next = r2[30:0];
                q_next   = {q_reg[ppe_pkg::QUO_W-2:0], 1'b0};
            end
            cnt_next = cnt_reg - 4'd1;
            if (cnt_reg == 4'd0)
            begin
                busy_next = 1'b0;
                done_next = 1'b1;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= 4'd0;
        end
        else
        begin
            busy_reg <= busy_next;
            done_reg <= done_next;
            cnt_reg  <= cnt_next;
        end
    end

    always_ff @(posedge clk)
    begin
        rem_reg <= rem_next;
        den_reg <= den_next;
        q_reg   <= q_next;
    end

    assign done = done_reg;
    assign quo  = q_reg;

endmodule

`default_nettype wire

>>> hw/rtl/particle_pool_engine.sv
// Top level of the particle pool engine: sequencer, config registers, slot RAM.
// Depends on ppe_pkg, ppe_ram, ppe_mul and ppe_div.
//
//  channel  | signals                                   | moves
//  ---------+-------------------------------------------+---------------------------
//  item     | item_valid, item_ready, item              | one op: emit, tick or read
//  result   | result_valid, result_ready, result        | one result item per op
//  config   | psel, penable, pwrite, paddr, pwdata,     | register i at byte 4*i
//           | prdata, pready                            |
//
// Sequencing: emit, tick and read share the one multiplier, read also waits on
// the divider, and tick walks every slot through the slot RAM, writing back
// live slots only.
// Reset: a clearing pass marks every slot inactive; no item is taken during it,
// config writes are.
// Stalls: a finished result waits in the output register while the next item
// is taken; an op ends only once that register is free.
`timescale 1ns / 1ps
`default_nettype none

module particle_pool_engine #(
    parameter int POOL_SIZE = 1024
) (
    input  wire logic              clk,
    input  wire logic              rst_n,
    input  wire logic              item_valid,
    output logic                   item_ready,
    input  wire ppe_pkg::item_t    item,
    output logic                   result_valid,
    input  wire logic              result_ready,
    output ppe_pkg::result_t       result,
    input  wire logic              psel,
    input  wire logic              penable,
    input  wire logic              pwrite,
    input  wire logic [4:0]        paddr,
    input  wire logic [31:0]       pwdata,
    output logic [31:0]            prdata,
    output logic                   pready
);

    localparam int PW = $clog2(POOL_SIZE);
    localparam logic [PW-1:0] LAST = PW'(POOL_SIZE - 1);
    localparam int EW = $bits(ppe_pkg::entry_t);

    typedef enum logic [3:0] {
        S_CLEAR, S_IDLE, S_EMIT, S_WRITE, S_TINIT, S_TRD, S_TWAIT, S_TMUL,
        S_RRD, S_RWAIT, S_RDIV, S_RMUL, S_FINISH
    } state_t;

    // configuration registers
    logic [31:0]        color_start_reg, color_finish_reg;
    logic signed [31:0] size_start_reg, size_finish_reg;
    logic [30:0]        size_spread_reg, life_span_reg, spread_x_reg, spread_y_reg;
    logic               cfg_wr;

    state_t              state_reg, state_next;
    logic [2:0]          step_reg, step_next;
    logic [PW-1:0]       idx_reg, idx_next;
    logic [PW-1:0]       ptr_reg, ptr_next;
    ppe_pkg::item_t      cur_reg, cur_next;
    ppe_pkg::entry_t     ent_reg, ent_next;
    ppe_pkg::result_t    res_reg, res_next;
    ppe_pkg::result_t    out_reg, out_next;
    logic                out_valid_reg, out_valid_next;
    logic signed [31:0]  spin_reg, spin_next;
    logic signed [46:0]  dx_reg, dx_next, dy_reg, dy_next;
    logic signed [63:0]  acc_reg, acc_next;
    logic [16:0]         f_reg, f_next;

    logic signed [32:0]  mul_a, mul_b;
    logic signed [65:0]  mul_p;
    logic                div_start, div_done;
    logic [30:0]         div_num, div_den;
    logic [ppe_pkg::QUO_W-1:0] div_q;
    logic                ram_we;
    logic [PW-1:0]       ram_waddr, ram_raddr;
    logic [EW-1:0]       ram_wdata, ram_rdata;

    ppe_ram #(.WIDTH(EW), .DEPTH(POOL_SIZE)) u_ram (
        .clk   (clk),
        .we    (ram_we),
        .waddr (ram_waddr),
        .wdata (ram_wdata),
        .raddr (ram_raddr),
        .rdata (ram_rdata)
    );

    ppe_mul u_mul (
        .clk  (clk),
        .a    (mul_a),
        .b    (mul_b),
        .prod (mul_p)
    );

    ppe_div u_div (
        .clk   (clk),
        .rst_n (rst_n),
        .start (div_start),
        .num   (div_num),
        .den   (div_den),
        .done  (div_done),
        .quo   (div_q)
    );

    // ---------------- configuration port ----------------
    assign pready = 1'b1;
    assign cfg_wr = psel && penable && pwrite;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            color_start_reg  <= 32'hFFFFFFFF;
            color_finish_reg <= 32'h0;
            size_start_reg   <= 32'sd32768;
            size_spread_reg  <= 31'd19661;
            size_finish_reg  <= 32'sd0;
            life_span_reg    <= 31'd65536;
            spread_x_reg     <= 31'd0;
            spread_y_reg     <= 31'd0;
        end
        else if (cfg_wr)
        begin
            unique case (paddr[4:2])
                ppe_pkg::REG_COLOR_START:  color_start_reg  <= pwdata;
                ppe_pkg::REG_COLOR_FINISH: color_finish_reg <= pwdata;
                ppe_pkg::REG_SIZE_START:   size_start_reg   <= pwdata;
                ppe_pkg::REG_SIZE_SPREAD:  size_spread_reg  <= pwdata[30:0];
                ppe_pkg::REG_SIZE_FINISH:  size_finish_reg  <= pwdata;
                ppe_pkg::REG_LIFE_SPAN:    life_span_reg    <= pwdata[30:0];
                ppe_pkg::REG_SPREAD_X:     spread_x_reg     <= pwdata[30:0];
                ppe_pkg::REG_SPREAD_Y:     spread_y_reg     <= pwdata[30:0];
                default: ;
            endcase
        end
    end

    always_comb
    begin
        unique case (paddr[4:2])
            ppe_pkg::REG_COLOR_START:  prdata = color_start_reg;
            ppe_pkg::REG_COLOR_FINISH: prdata = color_finish_reg;
            ppe_pkg::REG_SIZE_START:   prdata = size_start_reg;
            ppe_pkg::REG_SIZE_SPREAD:  prdata = {1'b0, size_spread_reg};
            ppe_pkg::REG_SIZE_FINISH:  prdata = size_finish_reg;
            ppe_pkg::REG_LIFE_SPAN:    prdata = {1'b0, life_span_reg};
            ppe_pkg::REG_SPREAD_X:     prdata = {1'b0, spread_x_reg};
            ppe_pkg::REG_SPREAD_Y:     prdata = {1'b0, spread_y_reg};
            default:                   prdata = 32'h0;
        endcase
    end

    // ---------------- sequencer ----------------
    always_comb
    begin
        logic signed [49:0] rp;
        ppe_pkg::entry_t    rd;
        logic [31:0]        ptr_w;
        logic [31:0]        sel_w;
        logic [1:0]         kb;
        logic [1:0]         kr;
        logic [7:0]         cs_b, ce_b, cr_b;

        state_next     = state_reg;
        step_next      = step_reg;
        idx_next       = idx_reg;
        ptr_next       = ptr_reg;
        cur_next       = cur_reg;
        ent_next       = ent_reg;
        res_next       = res_reg;
        out_next       = out_reg;
        out_valid_next = out_valid_reg && !result_ready;
        spin_next      = spin_reg;
        dx_next        = dx_reg;
        dy_next        = dy_reg;
        acc_next       = acc_reg;
        f_next         = f_reg;
        mul_a          = 33'sd0;
        mul_b          = 33'sd0;
        div_start      = 1'b0;
        div_num        = ent_reg.life_rem[30:0];
        div_den        = ent_reg.life_tot[30:0];
        ram_we         = 1'b0;
        ram_waddr      = idx_reg;
        ram_wdata      = ent_reg;
        ram_raddr      = idx_reg;
        item_ready     = 1'b0;

        rp    = ppe_pkg::rnd16(mul_p);
        rd    = ppe_pkg::entry_t'(ram_rdata);
        ptr_w = 32'(ptr_reg);
        sel_w = {22'b0, cur_reg.slot_index};
        kb    = 2'(step_reg - 3'd1);
        kr    = 2'(step_reg - 3'd2);
        cs_b  = ent_reg.col_s[8*kb +: 8];
        ce_b  = ent_reg.col_f[8*kb +: 8];
        cr_b  = ent_reg.col_f[8*kr +: 8];

        unique case (state_reg)
            S_CLEAR:
            begin
                // sweep every slot to inactive
                ram_we    = 1'b1;
                ram_wdata = '0;
                if (idx_reg == LAST)
                begin
                    idx_next   = '0;
                    state_next = S_IDLE;
                end
                else
                begin
                    idx_next = idx_reg + 1'b1;
                end
            end

            S_IDLE:
            begin
                item_ready = 1'b1;
                if (item_valid)
                begin
                    cur_next  = item;
                    res_next  = '0;
                    step_next = 3'd0;
                    case (item.op)
                        ppe_pkg::OP_EMIT:
                        begin
                            res_next.slot = ptr_w[ppe_pkg::SLOT_W-1:0];
                            idx_next      = ptr_reg;
                            state_next    = S_EMIT;
                        end
                        ppe_pkg::OP_TICK:
                        begin
                            idx_next   = '0;
                            state_next = S_TINIT;
                        end
                        ppe_pkg::OP_READ:
                        begin
                            res_next.slot = item.slot_index;
                            state_next    = S_RRD;
                        end
                        default:
                        begin
                            state_next = S_FINISH;
                        end
                    endcase
                end
            end

            S_EMIT:
            begin
                step_next = step_reg + 3'd1;
                case (step_reg)
                    3'd0:
                    begin
                        ent_next.live     = 1'b1;
                        ent_next.pos_x    = cur_reg.pos_x;
                        ent_next.pos_y    = cur_reg.pos_y;
                        ent_next.col_s    = color_start_reg;
                        ent_next.col_f    = color_finish_reg;
                        ent_next.size_f   = size_finish_reg;
                        ent_next.life_tot = $signed({1'b0, life_span_reg});
                        ent_next.life_rem = $signed({1'b0, life_span_reg});
                        mul_a = $signed({17'b0, cur_reg.random_bits[15:0]});
                        mul_b = ppe_pkg::ROT_GAIN;
                    end
                    3'd1:
                    begin
                        ent_next.rot = rp[31:0];
                        mul_a = $signed({2'b0, spread_x_reg});
                        mul_b = $signed({17'b0, cur_reg.random_bits[31:16]}) - ppe_pkg::HALF_Q16;
                    end
                    3'd2:
                    begin
                        ent_next.vel_x = ppe_pkg::sat32(64'(cur_reg.vel_x) + 64'(rp));
                        mul_a = $signed({2'b0, spread_y_reg});
                        mul_b = $signed({17'b0, cur_reg.random_bits[47:32]}) - ppe_pkg::HALF_Q16;
                    end
                    3'd3:
                    begin
                        ent_next.vel_y = ppe_pkg::sat32(64'(cur_reg.vel_y) + 64'(rp));
                        mul_a = $signed({2'b0, size_spread_reg});
                        mul_b = $signed({17'b0, cur_reg.random_bits[63:48]}) - ppe_pkg::HALF_Q16;
                    end
                    default:
                    begin
                        ent_next.size_s = ppe_pkg::sat32(64'(size_start_reg) + 64'(rp));
                        state_next      = S_WRITE;
                    end
                endcase
            end

            S_WRITE:
            begin
                ram_we = 1'b1;
                if (cur_reg.op == ppe_pkg::OP_EMIT)
                begin
                    // step the emit pointer down, wrap below slot zero
                    ptr_next   = (ptr_reg == '0) ? LAST : ptr_reg - 1'b1;
                    state_next = S_FINISH;
                end
                else if (idx_reg == LAST)
                begin
                    state_next = S_FINISH;
                end
                else
                begin
                    idx_next   = idx_reg + 1'b1;
                    state_next = S_TRD;
                end
            end

            S_TINIT:
            begin
                // spin increment is the same for every slot of this tick
                mul_a = $signed({2'b0, cur_reg.time_step});
                mul_b = ppe_pkg::SPIN_GAIN;
                if (step_reg != 3'd0)
                begin
                    spin_next  = rp[31:0];
                    state_next = S_TRD;
                end
                step_next = 3'd1;
            end

            S_TRD:
            begin
                state_next = S_TWAIT;
            end

            S_TWAIT:
            begin
                ent_next  = rd;
                step_next = 3'd0;
                if (!rd.live)
                begin
                    // skip the write-back of an empty slot
                    if (idx_reg == LAST)
                    begin
                        state_next = S_FINISH;
                    end
                    else
                    begin
                        idx_next   = idx_reg + 1'b1;
                        state_next = S_TRD;
                    end
                end
                else if (rd.life_rem <= 32'sd0)
                begin
                    ent_next.live = 1'b0;
                    state_next    = S_WRITE;
                end
                else
                begin
                    state_next = S_TMUL;
                end
            end

            S_TMUL:
            begin
                step_next = step_reg + 3'd1;
                case (step_reg)
                    3'd0:
                    begin
                        mul_a = 33'(ent_reg.vel_x);
                        mul_b = $signed({2'b0, cur_reg.time_step});
                    end
                    3'd1:
                    begin
                        dx_next = rp[46:0];
                        mul_a   = 33'(ent_reg.vel_y);
                        mul_b   = $signed({2'b0, cur_reg.time_step});
                    end
                    3'd2:
                    begin
                        // split the step into high and low halves for the gain
                        dy_next = rp[46:0];
                        mul_a   = 33'($signed(dx_reg[46:16]));
                        mul_b   = ppe_pkg::MOVE_GAIN;
                    end
                    3'd3:
                    begin
                        acc_next = $signed(mul_p[63:0]);
                        mul_a    = $signed({17'b0, dx_reg[15:0]});
                        mul_b    = ppe_pkg::MOVE_GAIN;
                    end
                    3'd4:
                    begin
                        ent_next.pos_x = ppe_pkg::sat32(64'(ent_reg.pos_x) + acc_reg + 64'(rp));
                        mul_a = 33'($signed(dy_reg[46:16]));
                        mul_b = ppe_pkg::MOVE_GAIN;
                    end
                    3'd5:
                    begin
                        acc_next = $signed(mul_p[63:0]);
                        mul_a    = $signed({17'b0, dy_reg[15:0]});
                        mul_b    = ppe_pkg::MOVE_GAIN;
                    end
                    default:
                    begin
                        ent_next.pos_y    = ppe_pkg::sat32(64'(ent_reg.pos_y) + acc_reg
                                                           + 64'(rp));
                        ent_next.life_rem = ent_reg.life_rem
                                            - $signed({1'b0, cur_reg.time_step});
                        ent_next.rot      = ppe_pkg::sat32(64'(ent_reg.rot) + 64'(spin_reg));
                        state_next        = S_WRITE;
                    end
                endcase
            end

            S_RRD:
            begin
                ram_raddr = sel_w[PW-1:0];
                if (sel_w >= 32'(POOL_SIZE))
                begin
                    state_next = S_FINISH;
                end
                else
                begin
                    state_next = S_RWAIT;
                end
            end

            S_RWAIT:
            begin
                ent_next  = rd;
                step_next = 3'd0;
                if (!rd.live)
                begin
                    state_next = S_FINISH;
                end
                else
                begin
                    res_next.active       = 1'b1;
                    res_next.out_pos_x    = rd.pos_x;
                    res_next.out_pos_y    = rd.pos_y;
                    res_next.out_rotation = rd.rot;
                    if (rd.life_tot <= 32'sd0 || rd.life_rem <= 32'sd0)
                    begin
                        f_next     = 17'd0;
                        state_next = S_RMUL;
                    end
                    else if (rd.life_rem >= rd.life_tot)
                    begin
                        f_next     = 17'd65536;
                        state_next = S_RMUL;
                    end
                    else
                    begin
                        div_start  = 1'b1;
                        div_num    = rd.life_rem[30:0];
                        div_den    = rd.life_tot[30:0];
                        state_next = S_RDIV;
                    end
                end
            end

            S_RDIV:
            begin
                if (div_done)
                begin
                    f_next     = {1'b0, div_q};
                    state_next = S_RMUL;
                end
            end

            S_RMUL:
            begin
                step_next = step_reg + 3'd1;
                if (step_reg == 3'd0)
                begin
                    mul_a = 33'(ent_reg.size_s) - 33'(ent_reg.size_f);
                    mul_b = $signed({16'b0, f_reg});
                end
                else
                begin
                    if (step_reg == 3'd1)
                    begin
                        res_next.out_size = ppe_pkg::sat32(64'(ent_reg.size_f) + 64'(rp));
                    end
                    else
                    begin
                        res_next.out_color[8*kr +: 8] = cr_b + rp[7:0];
                    end
                    if (step_reg == 3'd5)
                    begin
                        state_next = S_FINISH;
                    end
                    else
                    begin
                        // blend one color byte a pass
                        mul_a = $signed({25'b0, cs_b}) - $signed({25'b0, ce_b});
                        mul_b = $signed({16'b0, f_reg});
                    end
                end
            end

            S_FINISH:
            begin
                if (!out_valid_reg || result_ready)
                begin
                    out_next       = res_reg;
                    out_valid_next = 1'b1;
                    state_next     = S_IDLE;
                end
            end

            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_CLEAR;
            step_reg      <= 3'd0;
            idx_reg       <= '0;
            ptr_reg       <= LAST;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            step_reg      <= step_next;
            idx_reg       <= idx_next;
            ptr_reg       <= ptr_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        cur_reg  <= cur_next;
        ent_reg  <= ent_next;
        res_reg  <= res_next;
        out_reg  <= out_next;
        spin_reg <= spin_next;
        dx_reg   <= dx_next;
        dy_reg   <= dy_next;
        acc_reg  <= acc_next;
        f_reg    <= f_next;
    end

    assign result_valid = out_valid_reg;
    assign result       = out_reg;

    // ---------------- assertions ----------------
    a_div_done_in_wait: assert property (@(posedge clk) disable iff (!rst_n)
        div_done |-> state_reg == S_RDIV)
        else $error("divider finished outside its wait state");

    a_ptr_moves_on_emit: assert property (@(posedge clk) disable iff (!rst_n)
        !$stable(ptr_reg) |-> ($past(state_reg) == S_WRITE
                               && $past(cur_reg.op) == ppe_pkg::OP_EMIT))
        else $error("emit pointer moved outside an emit write-back");

    a_result_from_finish: assert property (@(posedge clk) disable iff (!rst_n)
        $rose(result_valid) |-> $past(state_reg) == S_FINISH)
        else $error("result raised outside the finish state");

endmodule

`default_nettype wire
